// ===== rtl/tccw_pkg.sv =====
// tccw_pkg: shared types and constants for the text console character writer
// depends on nothing; used by every module of the block
`default_nettype none

package tccw_pkg;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 8;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;

  localparam logic [7:0]  CH_NEWLINE  = 8'd10;
  localparam logic [7:0]  CH_RETURN   = 8'd13;
  localparam logic [7:0]  CH_TAB      = 8'd9;
  localparam logic [7:0]  CH_SPACE    = 8'd32;
  localparam logic [7:0]  COLOR_RESET = 8'h0F;
  localparam logic [15:0] RESET_CELL  = 16'h0F20;
  localparam int          TAB_STEP    = 4;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_CLEAR,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic             wr;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             rd_ok;
    logic             scroll;
    logic [ROW_W-1:0] new_row;
    logic [COL_W-1:0] new_col;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tccw_front.sv =====
// tccw_front: owns the cursor, classifies each item and builds a command
// depends on tccw_pkg
`default_nettype none

module tccw_front #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [1:0]      req_type,
  input  wire logic [7:0]      char_code,
  input  wire logic [7:0]      row_sel,
  input  wire logic [7:0]      col_sel,
  output tccw_pkg::cmd_t       cmd
);

  localparam logic [tccw_pkg::COL_W:0] COLS_EXT = (tccw_pkg::COL_W + 1)'(COLS);
  localparam logic [tccw_pkg::ROW_W:0] ROWS_EXT = (tccw_pkg::ROW_W + 1)'(ROWS);
  localparam logic [tccw_pkg::COL_W:0] TAB_ADD  = (tccw_pkg::COL_W + 1)'(tccw_pkg::TAB_STEP);
  localparam logic [tccw_pkg::COL_W:0] TAB_MASK =
    ~((tccw_pkg::COL_W + 1)'(tccw_pkg::TAB_STEP - 1));

  logic [tccw_pkg::ROW_W-1:0] row_q;
  logic [tccw_pkg::COL_W-1:0] col_q;
  logic [tccw_pkg::COL_W:0]   ncol;
  logic [tccw_pkg::ROW_W:0]   nrow;
  tccw_pkg::req_t             req;

  assign req = tccw_pkg::req_t'(req_type);

  always_comb begin
    ncol        = {1'b0, col_q};
    nrow        = {1'b0, row_q};
    cmd.op      = tccw_pkg::CMD_PUT;
    cmd.wr      = 1'b0;
    cmd.ch      = char_code;
    cmd.row     = row_q;
    cmd.col     = col_q;
    cmd.rd_ok   = 1'b0;
    cmd.scroll  = 1'b0;
    unique case (req)
      tccw_pkg::REQ_PUT: begin
        priority if (char_code == tccw_pkg::CH_NEWLINE) begin
          ncol = '0;
          nrow = nrow + 1'b1;
        end else if (char_code == tccw_pkg::CH_RETURN) begin
          ncol = '0;
        end else if (char_code == tccw_pkg::CH_TAB) begin
          ncol = (ncol + TAB_ADD) & TAB_MASK;
        end else begin
          cmd.wr = 1'b1;
          ncol   = ncol + 1'b1;
        end
        if (ncol >= COLS_EXT) begin
          ncol = '0;
          nrow = nrow + 1'b1;
        end
        if (nrow >= ROWS_EXT) begin
          cmd.scroll = 1'b1;
          nrow       = ROWS_EXT - 1'b1;
        end
      end
      tccw_pkg::REQ_SET: begin
        if (row_sel < 8'(ROWS)) begin
          nrow = (tccw_pkg::ROW_W + 1)'(row_sel);
        end
        if ({1'b0, col_sel} < COLS_EXT) begin
          ncol = {1'b0, col_sel};
        end
      end
      tccw_pkg::REQ_CLEAR: begin
        cmd.op = tccw_pkg::CMD_CLEAR;
        ncol   = '0;
        nrow   = '0;
      end
      tccw_pkg::REQ_READ: begin
        cmd.op    = tccw_pkg::CMD_READ;
        cmd.row   = row_sel[tccw_pkg::ROW_W-1:0];
        cmd.col   = col_sel;
        cmd.rd_ok = (row_sel < 8'(ROWS)) && ({1'b0, col_sel} < COLS_EXT);
      end
      default: begin
      end
    endcase
    cmd.new_row = nrow[tccw_pkg::ROW_W-1:0];
    cmd.new_col = ncol[tccw_pkg::COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
      col_q <= '0;
    end else if (take) begin
      row_q <= cmd.new_row;
      col_q <= cmd.new_col;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccw_fifo.sv =====
// tccw_fifo: two-entry command queue between front and back
// depends on tccw_pkg
`default_nettype none

module tccw_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tccw_pkg::cmd_t  push_data,
  input  wire logic            pop,
  output tccw_pkg::cmd_t       pop_data,
  output logic                 empty,
  output logic                 full
);

  tccw_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccw_back.sv =====
// tccw_back: screen memory, row ring offset, fill sweeps and result output
// depends on tccw_pkg
`default_nettype none

module tccw_back #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [7:0]                      text_color,
  input  wire tccw_pkg::cmd_t                  head,
  input  wire logic                            empty,
  output logic                                 pop,
  output logic                                 init_busy,
  output logic                                 done,
  output logic [tccw_pkg::OUT_ROW_W-1:0]       cursor_row,
  output logic [tccw_pkg::OUT_COL_W-1:0]       cursor_col,
  output logic [15:0]                          cell_entry,
  output logic                                 scrolled
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [tccw_pkg::ROW_W:0]   ROWS_EXT = (tccw_pkg::ROW_W + 1)'(ROWS);
  localparam logic [tccw_pkg::ROW_W-1:0] ROW_LAST = tccw_pkg::ROW_W'(ROWS - 1);
  localparam logic [AW-1:0]              COLS_A   = AW'(COLS);
  localparam logic [AW-1:0]              LAST_A   = AW'(CELLS - 1);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_BLANK,
    S_READ
  } state_t;

  state_t                     state;
  tccw_pkg::cmd_t             cmd_q;
  logic [tccw_pkg::ROW_W-1:0] top;
  logic [AW-1:0]              sweep_addr;
  logic [AW-1:0]              sweep_last;
  logic [15:0]                sweep_data;
  logic [15:0]                mem [CELLS];
  logic [15:0]                rd_data;

  logic [tccw_pkg::ROW_W:0]   phys_sum;
  logic [tccw_pkg::ROW_W-1:0] phys_row;
  logic [AW-1:0]              head_addr;
  logic [AW-1:0]              top_base;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [15:0]                wdata;

  assign pop       = (state == S_IDLE) && !empty;
  assign init_busy = (state == S_INIT);

  always_comb begin
    phys_sum = {1'b0, head.row} + {1'b0, top};
    if (phys_sum >= ROWS_EXT) begin
      phys_sum = phys_sum - ROWS_EXT;
    end
    phys_row  = phys_sum[tccw_pkg::ROW_W-1:0];
    head_addr = AW'(AW'(phys_row) * COLS_A) + AW'(head.col);
    top_base  = AW'(AW'(top) * COLS_A);
  end

  always_comb begin
    we    = 1'b0;
    waddr = head_addr;
    wdata = {text_color, head.ch};
    if (state == S_INIT || state == S_BLANK) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = sweep_data;
    end else if (pop && head.op == tccw_pkg::CMD_PUT && head.wr) begin
      we = 1'b1;
    end
  end

  // screen memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[head_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      top        <= '0;
      sweep_addr <= '0;
      sweep_last <= LAST_A;
      sweep_data <= tccw_pkg::RESET_CELL;
      done       <= 1'b0;
      cursor_row <= '0;
      cursor_col <= '0;
      cell_entry <= '0;
      scrolled   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            cmd_q <= head;
            unique case (head.op)
              tccw_pkg::CMD_PUT: begin
                if (head.scroll) begin
                  sweep_addr <= top_base;
                  sweep_last <= top_base + COLS_A - 1'b1;
                  sweep_data <= {text_color, tccw_pkg::CH_SPACE};
                  state      <= S_BLANK;
                end else begin
                  done       <= 1'b1;
                  cursor_row <= head.new_row[tccw_pkg::OUT_ROW_W-1:0];
                  cursor_col <= head.new_col[tccw_pkg::OUT_COL_W-1:0];
                  cell_entry <= '0;
                  scrolled   <= 1'b0;
                end
              end
              tccw_pkg::CMD_CLEAR: begin
                sweep_addr <= '0;
                sweep_last <= LAST_A;
                sweep_data <= {text_color, tccw_pkg::CH_SPACE};
                state      <= S_BLANK;
              end
              tccw_pkg::CMD_READ: begin
                if (head.rd_ok) begin
                  state <= S_READ;
                end else begin
                  done       <= 1'b1;
                  cursor_row <= head.new_row[tccw_pkg::OUT_ROW_W-1:0];
                  cursor_col <= head.new_col[tccw_pkg::OUT_COL_W-1:0];
                  cell_entry <= '0;
                  scrolled   <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_BLANK: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sweep_last) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            cursor_row <= cmd_q.new_row[tccw_pkg::OUT_ROW_W-1:0];
            cursor_col <= cmd_q.new_col[tccw_pkg::OUT_COL_W-1:0];
            cell_entry <= '0;
            scrolled   <= cmd_q.scroll;
            if (cmd_q.op == tccw_pkg::CMD_CLEAR) begin
              top <= '0;
            end else if (top == ROW_LAST) begin
              top <= '0;
            end else begin
              top <= top + 1'b1;
            end
          end
        end
        S_READ: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          cursor_row <= cmd_q.new_row[tccw_pkg::OUT_ROW_W-1:0];
          cursor_col <= cmd_q.new_col[tccw_pkg::OUT_COL_W-1:0];
          cell_entry <= rd_data;
          scrolled   <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_char_writer_unit.sv =====
// text_console_char_writer_unit: character-cell text console, top level
// depends on tccw_pkg, tccw_front, tccw_fifo, tccw_back
//
// usage:
//   an item (req_type, char_code, row_sel, col_sel) is taken at a clock edge
//   with start high and busy low; each item gives exactly one result, shown
//   on cursor_row, cursor_col, cell_entry and scrolled for one cycle with
//   done high, in the order the items were taken. The user writes text_color
//   with cfg_we and cfg_wdata only while the block is idle; it is not enforced
// work per item:
//   put without scroll, set cursor, out-of-range read: handled in the idle state
//   read cell: one registered read of the screen memory
//   put that scrolls: one row blanked, rows rotate by offset
//   clear: every cell written once
// throughput: one item a cycle for put, set cursor and out-of-range read while
//   busy is low; read cell, a scrolling put and clear hold the back until done,
//   and a two-item queue lets the front keep taking until it fills
// reset: cursor homes, text_color is 15 and a fill pass writes 0x0F20 to all
//   ROWS * COLS cells, busy staying high during that pass
// results cannot be held off; done lasts exactly one cycle per item
`default_nettype none

module text_console_char_writer_unit #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          req_type,
  input  wire logic [7:0]                          char_code,
  input  wire logic [7:0]                          row_sel,
  input  wire logic [7:0]                          col_sel,
  input  wire logic                                cfg_we,
  input  wire logic [7:0]                          cfg_wdata,
  output logic                                     done,
  output logic [tccw_pkg::OUT_ROW_W-1:0]           cursor_row,
  output logic [tccw_pkg::OUT_COL_W-1:0]           cursor_col,
  output logic [15:0]                              cell_entry,
  output logic                                     scrolled
);

  logic [7:0]     text_color;
  logic           take;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           init_busy;
  tccw_pkg::cmd_t front_cmd;
  tccw_pkg::cmd_t head_cmd;

  assign busy = q_full || init_busy;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tccw_pkg::COLOR_RESET;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  tccw_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req_type  (req_type),
    .char_code (char_code),
    .row_sel   (row_sel),
    .col_sel   (col_sel),
    .cmd       (front_cmd)
  );

  tccw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (front_cmd),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .empty     (q_empty),
    .full      (q_full)
  );

  tccw_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .head       (head_cmd),
    .empty      (q_empty),
    .pop        (q_pop),
    .init_busy  (init_busy),
    .done       (done),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_entry (cell_entry),
    .scrolled   (scrolled)
  );

endmodule

`default_nettype wire

// ===== sim/tccw_console_checker.sv =====
`timescale 1ns / 1ps
// tccw_console_checker: watches the item, config and result ports of the text console,
// keeps its own screen, cursor and color, predicts each result and compares it
// depends on tccw_pkg for request codes, character constants, widths and reset values
module tccw_console_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     req_type,
  input  logic [7:0]                     char_code,
  input  logic [7:0]                     row_sel,
  input  logic [7:0]                     col_sel,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           done,
  input  logic [tccw_pkg::OUT_ROW_W-1:0] cursor_row,
  input  logic [tccw_pkg::OUT_COL_W-1:0] cursor_col,
  input  logic [15:0]                    cell_entry,
  input  logic                           scrolled,
  output int                             fail_count,
  output int                             pending
);

  localparam int CELLS = ROWS * COLS;

  typedef struct packed {
    logic [tccw_pkg::OUT_ROW_W-1:0] row;
    logic [tccw_pkg::OUT_COL_W-1:0] col;
    logic [15:0]                    entry;
    logic                           scr;
  } cursor_report_t;

  logic [15:0]    screen [CELLS];
  int             row_pos;
  int             col_pos;
  logic [7:0]     color;
  cursor_report_t awaited_reports [$];
  int             errs;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errs++;
  endtask

  task automatic scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {color, tccw_pkg::CH_SPACE};
    row_pos = ROWS - 1;
  endtask

  task automatic apply_console_request(input tccw_pkg::req_t req, input logic [7:0] ch,
                                       input logic [7:0] rs, input logic [7:0] cs,
                                       output cursor_report_t rep);
    logic [15:0] entry;
    logic        scr;
    entry = '0;
    scr   = 1'b0;
    case (req)
      tccw_pkg::REQ_PUT: begin
        if (ch == tccw_pkg::CH_NEWLINE) begin
          col_pos = 0;
          row_pos++;
        end else if (ch == tccw_pkg::CH_RETURN) begin
          col_pos = 0;
        end else if (ch == tccw_pkg::CH_TAB) begin
          col_pos = (col_pos + tccw_pkg::TAB_STEP) & ~(tccw_pkg::TAB_STEP - 1);
        end else begin
          screen[row_pos * COLS + col_pos] = {color, ch};
          col_pos++;
        end
        if (col_pos >= COLS) begin
          col_pos = 0;
          row_pos++;
        end
        if (row_pos >= ROWS) begin
          scroll_screen();
          scr = 1'b1;
        end
      end
      tccw_pkg::REQ_SET: begin
        if (rs < ROWS) row_pos = int'(rs);
        if (cs < COLS) col_pos = int'(cs);
      end
      tccw_pkg::REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {color, tccw_pkg::CH_SPACE};
        row_pos = 0;
        col_pos = 0;
      end
      default: begin
        if (rs < ROWS && cs < COLS) entry = screen[rs * COLS + cs];
      end
    endcase
    rep.row   = row_pos[tccw_pkg::OUT_ROW_W-1:0];
    rep.col   = col_pos[tccw_pkg::OUT_COL_W-1:0];
    rep.entry = entry;
    rep.scr   = scr;
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    cursor_report_t got;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = tccw_pkg::RESET_CELL;
      row_pos = 0;
      col_pos = 0;
      color   = tccw_pkg::COLOR_RESET;
      awaited_reports.delete();
      errs = 0;
    end else begin
      if (done) begin
        got = {cursor_row, cursor_col, cell_entry, scrolled};
        if (awaited_reports.size() == 0) begin
          report_mismatch("result with no item waiting", int'(got.row), -1);
        end else begin
          want = awaited_reports.pop_front();
          if (got.row != want.row)
            report_mismatch("cursor_row", int'(got.row), int'(want.row));
          if (got.col != want.col)
            report_mismatch("cursor_col", int'(got.col), int'(want.col));
          if (got.entry != want.entry)
            report_mismatch("cell_entry", int'(got.entry), int'(want.entry));
          if (got.scr != want.scr)
            report_mismatch("scrolled", int'(got.scr), int'(want.scr));
        end
      end
      if (cfg_we) color = cfg_wdata;
      if (start && !busy) begin
        apply_console_request(tccw_pkg::req_t'(req_type), char_code, row_sel, col_sel,
                              want);
        awaited_reports.push_back(want);
      end
    end
    fail_count <= errs;
    pending    <= awaited_reports.size();
  end

endmodule

// ===== sim/tb_text_console_char_writer_unit.sv =====
`timescale 1ns / 1ps
// tb_text_console_char_writer_unit: clock, reset, directed and random requests,
// color changes between phases, watchdog and verdict
// depends on text_console_char_writer_unit, tccw_console_checker and tccw_pkg
module tb_text_console_char_writer_unit;

  localparam int ROWS         = 25;
  localparam int COLS         = 80;
  localparam int RANDOM_ITEMS = 650;
  localparam int PHASES       = 5;
  localparam int IDLE_LIMIT   = 20000;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           start     = 1'b0;
  logic [1:0]                     req_type  = '0;
  logic [7:0]                     char_code = '0;
  logic [7:0]                     row_sel   = '0;
  logic [7:0]                     col_sel   = '0;
  logic                           cfg_we    = 1'b0;
  logic [7:0]                     cfg_wdata = '0;
  logic                           busy;
  logic                           done;
  logic [tccw_pkg::OUT_ROW_W-1:0] cursor_row;
  logic [tccw_pkg::OUT_COL_W-1:0] cursor_col;
  logic [15:0]                    cell_entry;
  logic                           scrolled;
  int                             fail_count;
  int                             pending;
  int                             idle_cycles = 0;
  bit                             burst = 1'b0;

  text_console_char_writer_unit #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .char_code(char_code), .row_sel(row_sel), .col_sel(col_sel),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .cursor_row(cursor_row), .cursor_col(cursor_col),
    .cell_entry(cell_entry), .scrolled(scrolled)
  );

  tccw_console_checker #(.ROWS(ROWS), .COLS(COLS)) console_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .char_code(char_code), .row_sel(row_sel), .col_sel(col_sel),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .cursor_row(cursor_row), .cursor_col(cursor_col),
    .cell_entry(cell_entry), .scrolled(scrolled),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_char_writer_unit test failed");
      $finish;
    end
  end

  task automatic send_item(input tccw_pkg::req_t req, input logic [7:0] ch,
                           input logic [7:0] rs, input logic [7:0] cs);
    start     <= 1'b1;
    req_type  <= req;
    char_code <= ch;
    row_sel   <= rs;
    col_sel   <= cs;
    do @(posedge clk); while (busy);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle_gap();
    int g;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait for the block to drain, then change the attribute byte
  task automatic write_color(input logic [7:0] shade);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= shade;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    int         pick;
    int         sub;
    logic [7:0] ch;
    logic [7:0] rs;
    logic [7:0] cs;
    pick = $urandom_range(0, 999);
    sub  = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    rs   = 8'($urandom_range(0, 255));
    cs   = 8'($urandom_range(0, 255));
    if (pick < 8) begin
      send_item(tccw_pkg::REQ_CLEAR, ch, rs, cs);
    end else if (pick < 580) begin
      if (sub < 12) ch = tccw_pkg::CH_NEWLINE;
      else if (sub < 17) ch = tccw_pkg::CH_RETURN;
      else if (sub < 25) ch = tccw_pkg::CH_TAB;
      else if (sub < 85) ch = 8'($urandom_range(32, 126));
      send_item(tccw_pkg::REQ_PUT, ch, rs, cs);
    end else begin
      if ($urandom_range(0, 9) != 0) rs = 8'($urandom_range(0, ROWS - 1));
      if ($urandom_range(0, 9) != 0) cs = 8'($urandom_range(0, COLS - 1));
      if (pick < 700) send_item(tccw_pkg::REQ_SET, ch, rs, cs);
      else send_item(tccw_pkg::REQ_READ, ch, rs, cs);
    end
  endtask

  initial begin
    logic [7:0] shade;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_color(8'h1E);

    // directed: byte extremes, control characters, wrap and scroll corners, cursor sets, reads and a clear
    send_item(tccw_pkg::REQ_PUT, 8'h41, 8'h00, 8'h00);                idle_gap();
    send_item(tccw_pkg::REQ_PUT, 8'h00, 8'hFF, 8'hFF);                idle_gap();
    send_item(tccw_pkg::REQ_PUT, 8'hFF, 8'h00, 8'h00);                idle_gap();
    send_item(tccw_pkg::REQ_PUT, tccw_pkg::CH_TAB, 8'h00, 8'h00);     idle_gap();
    send_item(tccw_pkg::REQ_PUT, tccw_pkg::CH_RETURN, 8'h00, 8'h00);  idle_gap();
    send_item(tccw_pkg::REQ_PUT, tccw_pkg::CH_NEWLINE, 8'h00, 8'h00); idle_gap();
    send_item(tccw_pkg::REQ_SET, 8'h00, 8'd24, 8'd79);                idle_gap();
    send_item(tccw_pkg::REQ_PUT, 8'h5A, 8'h00, 8'h00);                idle_gap();
    send_item(tccw_pkg::REQ_SET, 8'hFF, 8'd25, 8'd80);                idle_gap();
    send_item(tccw_pkg::REQ_SET, 8'h00, 8'hFF, 8'd10);                idle_gap();
    send_item(tccw_pkg::REQ_SET, 8'h00, 8'd3, 8'hFF);                 idle_gap();
    send_item(tccw_pkg::REQ_SET, 8'h00, 8'd24, 8'd77);                idle_gap();
    send_item(tccw_pkg::REQ_PUT, tccw_pkg::CH_TAB, 8'h00, 8'h00);     idle_gap();
    send_item(tccw_pkg::REQ_PUT, tccw_pkg::CH_NEWLINE, 8'h00, 8'h00); idle_gap();
    send_item(tccw_pkg::REQ_READ, 8'h00, 8'd0, 8'd0);                 idle_gap();
    send_item(tccw_pkg::REQ_READ, 8'hFF, 8'd24, 8'd79);               idle_gap();
    send_item(tccw_pkg::REQ_READ, 8'h00, 8'd23, 8'd0);                idle_gap();
    send_item(tccw_pkg::REQ_READ, 8'h00, 8'd25, 8'd0);                idle_gap();
    send_item(tccw_pkg::REQ_READ, 8'h00, 8'd0, 8'd80);                idle_gap();
    send_item(tccw_pkg::REQ_READ, 8'h00, 8'hFF, 8'hFF);               idle_gap();
    send_item(tccw_pkg::REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF);              idle_gap();
    send_item(tccw_pkg::REQ_READ, 8'h00, 8'd12, 8'd40);               idle_gap();
    send_item(tccw_pkg::REQ_SET, 8'h00, 8'd0, 8'd0);                  idle_gap();
    send_item(tccw_pkg::REQ_PUT, 8'h7E, 8'h00, 8'h00);                idle_gap();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) shade = 8'h00;
      else if (p == 1) shade = 8'hFF;
      else if (p == PHASES - 1) shade = tccw_pkg::COLOR_RESET;
      else shade = 8'($urandom_range(0, 255));
      write_color(shade);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        send_random_item();
        idle_gap();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("text_console_char_writer_unit test passed");
    end else begin
      $display("text_console_char_writer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tccw_pkg.sv
rtl/tccw_front.sv
rtl/tccw_fifo.sv
rtl/tccw_back.sv
rtl/text_console_char_writer_unit.sv
sim/tccw_console_checker.sv
sim/tb_text_console_char_writer_unit.sv
